/* src/lri_pkg.sv */
// Shared constants and types for the linear interpolation resampler.
`timescale 1ns / 1ps

package lri_pkg;

   localparam int MAX_CHANNELS_DEF = 8;
   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int FRAC_BITS_DEF    = 16;

   localparam int STEP_BITS      = 24;
   localparam int CHAN_BITS      = 4;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [CHAN_BITS-1:0] CHANNELS_RESET = 4'd2;
   localparam logic [STEP_BITS-1:0] PITCH_RESET    = 24'd65536;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CHANNELS = 4'd0,
      CSR_PITCH    = 4'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_MUL,
      ST_LOAD
   } state_type;

endpackage

/* src/linear_interp_resampler.sv */
// Top level of the linear interpolation resampler for interleaved audio frames.
`timescale 1ns / 1ps

// Each input beat carries one frame of up to MAX_CHANNELS signed samples; the
// block emits output frames at positions i * pitch_step (unsigned Q8.16, 1.0
// is one input frame) and computes each as prev + frac * (next - prev) in one
// lane per channel, with the product rounded toward zero. A frame that starts
// a stream is only stored. A frame with tlast set also flushes the positions
// in the interval after it, holding the frame's own value, and then the next
// beat starts a fresh stream. Each frame first goes through a setup step;
// every output beat it causes then goes through the lane multipliers and
// then the lane adders and the merge into the output register, a step that
// waits while that register holds an untaken beat. The output register lets
// the last beat of a frame wait on rsp_tready while the next frame is
// already taken. Lanes at or above the active channel count read zero. A
// channel count of zero acts as one, and a count above MAX_CHANNELS acts as
// MAX_CHANNELS; a pitch step below 2^FRAC_BITS / 32, rounded up, acts as that
// minimum, so a frame never causes more than 64 output beats. Configuration
// is written through the csr port, which is always ready. The user must write
// configuration only while the block is idle; the block does not enforce it.

module linear_interp_resampler
   import lri_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   localparam int DATA_W      = ((MAX_CHANNELS * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // Input frames.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [DATA_W-1:0]         req_tdata,   // sample_in_0 .. sample_in_7, lowest first
   input  logic                      req_tlast,   // final_frame
   // Output frames.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [DATA_W-1:0]         rsp_tdata,   // sample_out_0 .. sample_out_7, lowest first
   output logic                      rsp_tlast,   // run_last
   output logic                      rsp_tuser,   // stream_end
   // Register writes.
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int LANE_W   = $clog2(MAX_CHANNELS + 1);
   localparam int POS_W    = STEP_BITS + 1;
   localparam int MIN_STEP = ((1 << FRAC_BITS) + 31) / 32;
   localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << FRAC_BITS;

   // Configuration registers.
   logic [CHAN_BITS-1:0] chan_cfg_ff;
   logic [STEP_BITS-1:0] pitch_cfg_ff;

   // Frame state.
   state_type                       state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0]   cur_ff  [MAX_CHANNELS];
   logic signed [SAMPLE_BITS-1:0]   prev_ff [MAX_CHANNELS];
   logic                            fin_ff;
   logic                            have_prev_ff, have_prev_in;
   logic [STEP_BITS-1:0]            next_pos_ff, next_pos_in;
   logic [POS_W-1:0]                pos_ff, pos_in;
   logic                            held_ff, held_in;
   logic                            commit;

   // Output register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]               rsp_data_ff;
   logic                            rsp_last_ff, rsp_end_ff;
   logic                            out_load;
   logic                            out_last;

   logic                            req_fire;
   logic [LANE_W-1:0]               active_lanes;
   logic [POS_W-1:0]                step;
   logic [POS_W-1:0]                pos_next;
   logic [POS_W-1:0]                pos_wrap;
   logic [POS_W-1:0]                start_pos;
   logic [SAMPLE_BITS-1:0]          lane_result [MAX_CHANNELS];
   logic [DATA_W-1:0]               merged;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_cfg_ff  <= CHANNELS_RESET;
         pitch_cfg_ff <= PITCH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CHANNELS: chan_cfg_ff  <= csr_data[CHAN_BITS-1:0];
            CSR_PITCH:    pitch_cfg_ff <= csr_data[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Clamped register values.
   always_comb begin
      if (chan_cfg_ff == '0) begin
         active_lanes = LANE_W'(1);
      end else if (chan_cfg_ff > CHAN_BITS'(MAX_CHANNELS)) begin
         active_lanes = LANE_W'(MAX_CHANNELS);
      end else begin
         active_lanes = chan_cfg_ff[LANE_W-1:0];
      end
      if (pitch_cfg_ff < STEP_BITS'(MIN_STEP)) begin
         step = POS_W'(MIN_STEP);
      end else begin
         step = POS_W'(pitch_cfg_ff);
      end
   end

   // Frame capture; the stored previous frame is replaced when a frame is done.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            cur_ff[c] <= req_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
         end
         fin_ff <= req_tlast;
      end
      if (commit) begin
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            prev_ff[c] <= cur_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         next_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         next_pos_ff  <= next_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      held_ff <= held_in;
      if (out_load) begin
         rsp_data_ff <= merged;
         rsp_last_ff <= out_last;
         rsp_end_ff  <= out_last && fin_ff;
      end
   end

   assign pos_next  = pos_ff + step;
   assign pos_wrap  = pos_next - POS_ONE;
   // Start of a frame: once the interval to this frame is exhausted, the
   // position is measured from this frame instead.
   assign start_pos = have_prev_ff ? (pos_ff - POS_ONE) : pos_ff;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      held_in      = held_ff;
      have_prev_in = have_prev_ff;
      next_pos_in  = next_pos_ff;
      commit       = 1'b0;
      out_load     = 1'b0;
      out_last     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pos_in   = POS_W'(next_pos_ff);
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (have_prev_ff && (pos_ff < POS_ONE)) begin
               held_in  = 1'b0;
               state_in = ST_MUL;
            end else if (fin_ff && (start_pos < POS_ONE)) begin
               held_in  = 1'b1;
               pos_in   = start_pos;
               state_in = ST_MUL;
            end else begin
               commit   = 1'b1;
               pos_in   = start_pos;
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (pos_next < POS_ONE) begin
                  pos_in   = pos_next;
                  state_in = ST_MUL;
               end else if (!held_ff && fin_ff && (pos_wrap < POS_ONE)) begin
                  held_in  = 1'b1;
                  pos_in   = pos_wrap;
                  state_in = ST_MUL;
               end else begin
                  out_last = 1'b1;
                  commit   = 1'b1;
                  pos_in   = pos_wrap;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (commit) begin
         have_prev_in = !fin_ff;
         next_pos_in  = fin_ff ? '0 : pos_in[STEP_BITS-1:0];
      end
   end

   for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
      lri_lane #(
         .SAMPLE_BITS(SAMPLE_BITS),
         .FRAC_BITS  (FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .load  (state_ff == ST_MUL),
         .frac  (pos_ff[FRAC_BITS-1:0]),
         .base  (held_ff ? cur_ff[c] : prev_ff[c]),
         .target(cur_ff[c]),
         .result(lane_result[c])
      );
   end

   lri_merge #(
      .MAX_CHANNELS(MAX_CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .LANE_W      (LANE_W),
      .DATA_W      (DATA_W)
   ) u_merge (
      .lane_result (lane_result),
      .active_lanes(active_lanes),
      .merged      (merged)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_end_ff;

endmodule

/* src/lri_lane.sv */
// One channel lane: multiplies the fraction by the sample difference and adds the base.
`timescale 1ns / 1ps

module lri_lane
   import lri_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic        [FRAC_BITS-1:0]   frac,
   input  logic signed [SAMPLE_BITS-1:0] base,
   input  logic signed [SAMPLE_BITS-1:0] target,
   output logic        [SAMPLE_BITS-1:0] result
);

   localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

   logic signed [SAMPLE_BITS:0]   diff;
   logic signed [PROD_W-1:0]      product_in;
   logic signed [PROD_W-1:0]      product_ff;
   logic signed [SAMPLE_BITS-1:0] base_ff;
   logic signed [PROD_W-1:0]      quot;
   logic                          round_up;
   logic        [SAMPLE_BITS+1:0] sum;

   assign diff       = (SAMPLE_BITS+1)'(target) - (SAMPLE_BITS+1)'(base);
   assign product_in = $signed({1'b0, frac}) * diff;

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
         base_ff    <= base;
      end
   end

   // Arithmetic shift floors; a negative product with fraction bits left
   // is bumped by one so that the quotient truncates toward zero.
   assign quot     = product_ff >>> FRAC_BITS;
   assign round_up = product_ff[PROD_W-1] && (|product_ff[FRAC_BITS-1:0]);
   assign sum      = (SAMPLE_BITS+2)'(base_ff) + (SAMPLE_BITS+2)'(quot)
                     + (SAMPLE_BITS+2)'(round_up);
   assign result   = sum[SAMPLE_BITS-1:0];

endmodule

/* src/lri_merge.sv */
// Merges the lane results into one output word, zeroing lanes that are not in use.
`timescale 1ns / 1ps

module lri_merge
   import lri_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
   parameter int LANE_W       = 4,
   parameter int DATA_W       = 128
) (
   input  logic [SAMPLE_BITS-1:0] lane_result [MAX_CHANNELS],
   input  logic [LANE_W-1:0]      active_lanes,
   output logic [DATA_W-1:0]      merged
);

   always_comb begin
      merged = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         if (LANE_W'(c) < active_lanes) begin
            merged[c*SAMPLE_BITS +: SAMPLE_BITS] = lane_result[c];
         end
      end
   end

endmodule

/* src/lri_checker.sv */
// Port-level assertions for the resampler and the bind that attaches them.
`timescale 1ns / 1ps

module lri_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tlast,
   input logic rsp_tuser
);

   // A stalled output beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("output beat dropped while stalled");

   // The end-of-stream mark only rides on the last beat of a frame.
   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("stream end without run end");

   // A taken frame keeps the input side closed for at least the next cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken twice in a row");

   // While a frame still owes beats, no new frame is taken.
   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken before the run ended");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

bind linear_interp_resampler lri_checker u_lri_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tlast (rsp_tlast),
   .rsp_tuser (rsp_tuser)
);
